// ===== rtl/core/mesha_pkg.sv =====
`timescale 1ns / 1ps
// constants, action codes, initial values, round constants and rotate helpers for the hash peripheral
// no dependencies

package mesha_pkg;

	// action codes
	localparam logic [2:0] ACT_WRITE_TEXT = 3'd0;
	localparam logic [2:0] ACT_READ_TEXT  = 3'd1;
	localparam logic [2:0] ACT_LOAD       = 3'd2;
	localparam logic [2:0] ACT_PUT_BLOCK  = 3'd3;
	localparam logic [2:0] ACT_HASH       = 3'd4;

	// hash type codes
	localparam logic [1:0] HT_SHA1   = 2'd0;
	localparam logic [1:0] HT_SHA256 = 2'd1;
	localparam logic [1:0] HT_SHA384 = 2'd2;
	localparam logic [1:0] HT_SHA512 = 2'd3;

	localparam logic [31:0] IV1 [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};
	localparam logic [31:0] IV256 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [63:0] IV384 [8] = '{
		64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
		64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
		64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
	};
	localparam logic [63:0] IV512 [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [31:0] K1_0 = 32'h5a827999;
	localparam logic [31:0] K1_1 = 32'h6ed9eba1;
	localparam logic [31:0] K1_2 = 32'h8f1bbcdc;
	localparam logic [31:0] K1_3 = 32'hca62c1d6;

	function automatic logic [31:0] rotr32(logic [31:0] x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [63:0] rotr64(logic [63:0] x, int unsigned n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// round constants of the 64-bit engine; the sha-256 engine takes the high halves
	function automatic logic [63:0] k512(logic [6:0] idx);
		logic [63:0] k;
		unique case (idx)
			7'd0:  k = 64'h428a2f98d728ae22;
			7'd1:  k = 64'h7137449123ef65cd;
			7'd2:  k = 64'hb5c0fbcfec4d3b2f;
			7'd3:  k = 64'he9b5dba58189dbbc;
			7'd4:  k = 64'h3956c25bf348b538;
			7'd5:  k = 64'h59f111f1b605d019;
			7'd6:  k = 64'h923f82a4af194f9b;
			7'd7:  k = 64'hab1c5ed5da6d8118;
			7'd8:  k = 64'hd807aa98a3030242;
			7'd9:  k = 64'h12835b0145706fbe;
			7'd10: k = 64'h243185be4ee4b28c;
			7'd11: k = 64'h550c7dc3d5ffb4e2;
			7'd12: k = 64'h72be5d74f27b896f;
			7'd13: k = 64'h80deb1fe3b1696b1;
			7'd14: k = 64'h9bdc06a725c71235;
			7'd15: k = 64'hc19bf174cf692694;
			7'd16: k = 64'he49b69c19ef14ad2;
			7'd17: k = 64'hefbe4786384f25e3;
			7'd18: k = 64'h0fc19dc68b8cd5b5;
			7'd19: k = 64'h240ca1cc77ac9c65;
			7'd20: k = 64'h2de92c6f592b0275;
			7'd21: k = 64'h4a7484aa6ea6e483;
			7'd22: k = 64'h5cb0a9dcbd41fbd4;
			7'd23: k = 64'h76f988da831153b5;
			7'd24: k = 64'h983e5152ee66dfab;
			7'd25: k = 64'ha831c66d2db43210;
			7'd26: k = 64'hb00327c898fb213f;
			7'd27: k = 64'hbf597fc7beef0ee4;
			7'd28: k = 64'hc6e00bf33da88fc2;
			7'd29: k = 64'hd5a79147930aa725;
			7'd30: k = 64'h06ca6351e003826f;
			7'd31: k = 64'h142929670a0e6e70;
			7'd32: k = 64'h27b70a8546d22ffc;
			7'd33: k = 64'h2e1b21385c26c926;
			7'd34: k = 64'h4d2c6dfc5ac42aed;
			7'd35: k = 64'h53380d139d95b3df;
			7'd36: k = 64'h650a73548baf63de;
			7'd37: k = 64'h766a0abb3c77b2a8;
			7'd38: k = 64'h81c2c92e47edaee6;
			7'd39: k = 64'h92722c851482353b;
			7'd40: k = 64'ha2bfe8a14cf10364;
			7'd41: k = 64'ha81a664bbc423001;
			7'd42: k = 64'hc24b8b70d0f89791;
			7'd43: k = 64'hc76c51a30654be30;
			7'd44: k = 64'hd192e819d6ef5218;
			7'd45: k = 64'hd69906245565a910;
			7'd46: k = 64'hf40e35855771202a;
			7'd47: k = 64'h106aa07032bbd1b8;
			7'd48: k = 64'h19a4c116b8d2d0c8;
			7'd49: k = 64'h1e376c085141ab53;
			7'd50: k = 64'h2748774cdf8eeb99;
			7'd51: k = 64'h34b0bcb5e19b48a8;
			7'd52: k = 64'h391c0cb3c5c95a63;
			7'd53: k = 64'h4ed8aa4ae3418acb;
			7'd54: k = 64'h5b9cca4f7763e373;
			7'd55: k = 64'h682e6ff3d6b2b8a3;
			7'd56: k = 64'h748f82ee5defb2fc;
			7'd57: k = 64'h78a5636f43172f60;
			7'd58: k = 64'h84c87814a1f0ab72;
			7'd59: k = 64'h8cc702081a6439ec;
			7'd60: k = 64'h90befffa23631e28;
			7'd61: k = 64'ha4506cebde82bde9;
			7'd62: k = 64'hbef9a3f7b2c67915;
			7'd63: k = 64'hc67178f2e372532b;
			7'd64: k = 64'hca273eceea26619c;
			7'd65: k = 64'hd186b8c721c0c207;
			7'd66: k = 64'heada7dd6cde0eb1e;
			7'd67: k = 64'hf57d4f7fee6ed178;
			7'd68: k = 64'h06f067aa72176fba;
			7'd69: k = 64'h0a637dc5a2c898a6;
			7'd70: k = 64'h113f9804bef90dae;
			7'd71: k = 64'h1b710b35131c471b;
			7'd72: k = 64'h28db77f523047d84;
			7'd73: k = 64'h32caab7b40c72493;
			7'd74: k = 64'h3c9ebe0a15c9bebc;
			7'd75: k = 64'h431d67c49c100d4c;
			7'd76: k = 64'h4cc5d4becb3e42b6;
			7'd77: k = 64'h597f299cfc657e2a;
			7'd78: k = 64'h5fcb6fab3ad6faec;
			7'd79: k = 64'h6c44198c4a475817;
			default: k = 64'h0;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/core/multi_engine_sha_peripheral.sv =====
`timescale 1ns / 1ps
// hash peripheral top level: text words, three engine states, block buffer, shared round unit
// depends on mesha_pkg and mesha_ram
//
// usage
//   input channel (in_valid / in_stall) carries one transaction per action: write or read a
//   text word, load an engine state from the text words, put a block word, hash the block
//   output channel (out_valid / out_stall) returns one transaction per input: the text word
//   for a read, zero for everything else
//   register actions give a registered result that shows the next cycle
//   a hash first streams the block words out of the block ram into a sixteen-word schedule
//   window, then runs one round per cycle on the shared round unit (80, 64 or 80 rounds),
//   then, once the result slot is free, adds the state back and copies it to the text words
//   in_stall is high for the whole of a hash and whenever a result waits on a stalled
//   receiver; a stalled result holds its value
//   reset clears text words and engine states at once; the block buffer is not cleared

module multi_engine_sha_peripheral (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [4:0]  word_index,
	input  logic [31:0] data,
	input  logic [1:0]  hash_type,
	input  logic        first_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_LOADW, ST_ROUND, ST_FINAL} state_t;

	state_t      state_q;
	logic [1:0]  type_q;
	logic [5:0]  cnt_q;
	logic [6:0]  rnd_q;
	logic        out_valid_q;
	logic [31:0] read_data_q;

	// architectural state
	logic [31:0] text_q   [32];
	logic [31:0] sha1_q   [5];
	logic [31:0] sha256_q [8];
	logic [63:0] sha512_q [8];

	// working variables and schedule window (entry 0 is the current round word)
	logic [63:0]        v_q [8];
	logic [15:0][63:0]  win_q;

	logic        out_free;
	logic        acc;
	logic        is512;
	logic [5:0]  n_words;
	logic [6:0]  last_rnd;
	logic [31:0] ram_rd;

	logic [63:0] nv [8];
	logic [63:0] nw;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_free;
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	assign is512    = type_q[1];
	assign n_words  = is512 ? 6'd32 : 6'd16;
	assign last_rnd = (type_q == mesha_pkg::HT_SHA256) ? 7'd63 : 7'd79;

	// block buffer
	mesha_ram #(.WIDTH(32), .DEPTH(32)) u_block (
		.clk   (clk),
		.we    (acc && (action == mesha_pkg::ACT_PUT_BLOCK)),
		.waddr (word_index),
		.wdata (data),
		.raddr (cnt_q[4:0]),
		.rdata (ram_rd)
	);

	// shared round unit and schedule expansion
	always_comb begin
		logic [31:0] f1, k1, t1a, s0a, s1a, t1b, t2b, ch, mj, w0, w1, w14, w9;
		logic [63:0] s0c, s1c, t1c, t2c, chc, mjc, k64;
		k64 = mesha_pkg::k512(rnd_q);
		for (int i = 0; i < 8; i++) begin
			nv[i] = v_q[i];
		end
		nw  = 64'h0;
		f1  = 32'h0; k1 = 32'h0; t1a = 32'h0; s0a = 32'h0; s1a = 32'h0;
		t1b = 32'h0; t2b = 32'h0; ch = 32'h0; mj = 32'h0;
		w0  = win_q[0][31:0]; w1 = win_q[1][31:0];
		w14 = win_q[14][31:0]; w9 = win_q[9][31:0];
		s0c = 64'h0; s1c = 64'h0; t1c = 64'h0; t2c = 64'h0; chc = 64'h0; mjc = 64'h0;
		unique case (type_q)
			mesha_pkg::HT_SHA1: begin
				if (rnd_q < 7'd20) begin
					f1 = (v_q[1][31:0] & v_q[2][31:0]) | (~v_q[1][31:0] & v_q[3][31:0]);
					k1 = mesha_pkg::K1_0;
				end else if (rnd_q < 7'd40) begin
					f1 = v_q[1][31:0] ^ v_q[2][31:0] ^ v_q[3][31:0];
					k1 = mesha_pkg::K1_1;
				end else if (rnd_q < 7'd60) begin
					f1 = (v_q[1][31:0] & v_q[2][31:0]) | (v_q[1][31:0] & v_q[3][31:0])
						| (v_q[2][31:0] & v_q[3][31:0]);
					k1 = mesha_pkg::K1_2;
				end else begin
					f1 = v_q[1][31:0] ^ v_q[2][31:0] ^ v_q[3][31:0];
					k1 = mesha_pkg::K1_3;
				end
				t1a = {v_q[0][26:0], v_q[0][31:27]} + f1 + v_q[4][31:0] + k1 + w0;
				nv[0] = {32'h0, t1a};
				nv[1] = v_q[0];
				nv[2] = {32'h0, v_q[1][1:0], v_q[1][31:2]};
				nv[3] = v_q[2];
				nv[4] = v_q[3];
				s0a = win_q[13][31:0] ^ win_q[8][31:0] ^ win_q[2][31:0] ^ w0;
				nw  = {32'h0, s0a[30:0], s0a[31]};
			end
			mesha_pkg::HT_SHA256: begin
				s1a = mesha_pkg::rotr32(v_q[4][31:0], 6) ^ mesha_pkg::rotr32(v_q[4][31:0], 11)
					^ mesha_pkg::rotr32(v_q[4][31:0], 25);
				ch  = (v_q[4][31:0] & v_q[5][31:0]) ^ (~v_q[4][31:0] & v_q[6][31:0]);
				t1b = v_q[7][31:0] + s1a + ch + k64[63:32] + w0;
				s0a = mesha_pkg::rotr32(v_q[0][31:0], 2) ^ mesha_pkg::rotr32(v_q[0][31:0], 13)
					^ mesha_pkg::rotr32(v_q[0][31:0], 22);
				mj  = (v_q[0][31:0] & v_q[1][31:0]) ^ (v_q[0][31:0] & v_q[2][31:0])
					^ (v_q[1][31:0] & v_q[2][31:0]);
				t2b = s0a + mj;
				nv[7] = v_q[6]; nv[6] = v_q[5]; nv[5] = v_q[4];
				nv[4] = {32'h0, v_q[3][31:0] + t1b};
				nv[3] = v_q[2]; nv[2] = v_q[1]; nv[1] = v_q[0];
				nv[0] = {32'h0, t1b + t2b};
				s0a = mesha_pkg::rotr32(w1, 7) ^ mesha_pkg::rotr32(w1, 18) ^ (w1 >> 3);
				s1a = mesha_pkg::rotr32(w14, 17) ^ mesha_pkg::rotr32(w14, 19) ^ (w14 >> 10);
				t1a = w0 + s0a + w9 + s1a;
				nw  = {32'h0, t1a};
			end
			default: begin
				s1c = mesha_pkg::rotr64(v_q[4], 14) ^ mesha_pkg::rotr64(v_q[4], 18)
					^ mesha_pkg::rotr64(v_q[4], 41);
				chc = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
				t1c = v_q[7] + s1c + chc + k64 + win_q[0];
				s0c = mesha_pkg::rotr64(v_q[0], 28) ^ mesha_pkg::rotr64(v_q[0], 34)
					^ mesha_pkg::rotr64(v_q[0], 39);
				mjc = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
				t2c = s0c + mjc;
				nv[7] = v_q[6]; nv[6] = v_q[5]; nv[5] = v_q[4];
				nv[4] = v_q[3] + t1c;
				nv[3] = v_q[2]; nv[2] = v_q[1]; nv[1] = v_q[0];
				nv[0] = t1c + t2c;
				s0c = mesha_pkg::rotr64(win_q[1], 1) ^ mesha_pkg::rotr64(win_q[1], 8)
					^ (win_q[1] >> 7);
				s1c = mesha_pkg::rotr64(win_q[14], 19) ^ mesha_pkg::rotr64(win_q[14], 61)
					^ (win_q[14] >> 6);
				nw  = win_q[0] + s0c + win_q[9] + s1c;
			end
		endcase
	end

	// sequencer, architectural state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			type_q      <= mesha_pkg::HT_SHA1;
			cnt_q       <= 6'd0;
			rnd_q       <= 7'd0;
			out_valid_q <= 1'b0;
			read_data_q <= 32'h0;
			for (int i = 0; i < 32; i++) text_q[i] <= 32'h0;
			for (int i = 0; i < 5; i++) sha1_q[i] <= 32'h0;
			for (int i = 0; i < 8; i++) begin
				sha256_q[i] <= 32'h0;
				sha512_q[i] <= 64'h0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						out_valid_q <= (action != mesha_pkg::ACT_HASH);
						read_data_q <= 32'h0;
						unique case (action)
							mesha_pkg::ACT_WRITE_TEXT: text_q[word_index] <= data;
							mesha_pkg::ACT_READ_TEXT:  read_data_q <= text_q[word_index];
							mesha_pkg::ACT_LOAD: begin
								if (hash_type == mesha_pkg::HT_SHA1) begin
									for (int i = 0; i < 5; i++) sha1_q[i] <= text_q[i];
								end else if (hash_type == mesha_pkg::HT_SHA256) begin
									for (int i = 0; i < 8; i++) sha256_q[i] <= text_q[i];
								end else begin
									// 64-bit lanes: high half first
									for (int i = 0; i < 8; i++) begin
										sha512_q[i] <= {text_q[2*i], text_q[2*i+1]};
									end
								end
							end
							mesha_pkg::ACT_HASH: begin
								type_q  <= hash_type;
								cnt_q   <= 6'd0;
								state_q <= ST_LOADW;
								if (first_block) begin
									unique case (hash_type)
										mesha_pkg::HT_SHA1:
											for (int i = 0; i < 5; i++) sha1_q[i] <= mesha_pkg::IV1[i];
										mesha_pkg::HT_SHA256:
											for (int i = 0; i < 8; i++) sha256_q[i] <= mesha_pkg::IV256[i];
										mesha_pkg::HT_SHA384:
											for (int i = 0; i < 8; i++) sha512_q[i] <= mesha_pkg::IV384[i];
										default:
											for (int i = 0; i < 8; i++) sha512_q[i] <= mesha_pkg::IV512[i];
									endcase
								end
							end
							default: ;
						endcase
					end else if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_LOADW: begin
					if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == n_words) begin
						rnd_q   <= 7'd0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == last_rnd) state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					// wait for the result slot, then fold the working variables back
					if (out_free) begin
						out_valid_q <= 1'b1;
						read_data_q <= 32'h0;
						state_q     <= ST_IDLE;
						unique case (type_q)
							mesha_pkg::HT_SHA1: begin
								for (int i = 0; i < 5; i++) begin
									sha1_q[i] <= sha1_q[i] + v_q[i][31:0];
									text_q[i] <= sha1_q[i] + v_q[i][31:0];
								end
							end
							mesha_pkg::HT_SHA256: begin
								for (int i = 0; i < 8; i++) begin
									sha256_q[i] <= sha256_q[i] + v_q[i][31:0];
									text_q[i]   <= sha256_q[i] + v_q[i][31:0];
								end
							end
							default: begin
								for (int i = 0; i < 8; i++) begin
									sha512_q[i]   <= sha512_q[i] + v_q[i];
									text_q[2*i]   <= sha512_q[i][63:32] + v_q[i][63:32]
										+ {31'h0, ((sha512_q[i][31:0] + v_q[i][31:0])
										< sha512_q[i][31:0])};
									text_q[2*i+1] <= sha512_q[i][31:0] + v_q[i][31:0];
								end
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (state_q == ST_LOADW) begin
			// ram read data is registered, so it lags its address
			if (cnt_q != 6'd0) begin
				if (is512) begin
					for (int i = 0; i < 15; i++) win_q[i] <= {win_q[i][31:0], win_q[i+1][63:32]};
					win_q[15] <= {win_q[15][31:0], ram_rd};
				end else begin
					for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
					win_q[15] <= {32'h0, ram_rd};
				end
			end
			if (cnt_q == n_words) begin
				for (int i = 0; i < 8; i++) begin
					unique case (type_q)
						mesha_pkg::HT_SHA1:   v_q[i] <= (i < 5) ? {32'h0, sha1_q[i % 5]} : 64'h0;
						mesha_pkg::HT_SHA256: v_q[i] <= {32'h0, sha256_q[i]};
						default:              v_q[i] <= sha512_q[i];
					endcase
				end
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 8; i++) v_q[i] <= nv[i];
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= nw;
		end
	end

endmodule

// ===== rtl/core/mesha_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module mesha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/mesha_chk.sv =====
`timescale 1ns / 1ps
// port-level checks for the hash peripheral, bound to the top level
// depends on mesha_pkg and multi_engine_sha_peripheral

module mesha_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  action,
	input logic [4:0]  word_index,
	input logic [31:0] data,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] read_data
);

	logic acc;
	assign acc = in_valid && !in_stall;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data))
		else $error("stalled result changed");

	// register actions other than a read answer zero in the next cycle
	a_zero_reply: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (action == mesha_pkg::ACT_WRITE_TEXT || action == mesha_pkg::ACT_LOAD
			|| action == mesha_pkg::ACT_PUT_BLOCK) |=> out_valid && read_data == 32'h0)
		else $error("non-read action gave non-zero result");

	// a hash keeps the input side closed
	a_hash_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && action == mesha_pkg::ACT_HASH |=> in_stall)
		else $error("input accepted during hash");

	// a read straight after a write to the same word returns the written data
	a_write_read: assert property (@(posedge clk) disable iff (!arst_n)
		acc && action == mesha_pkg::ACT_READ_TEXT
			&& $past(acc && action == mesha_pkg::ACT_WRITE_TEXT)
			&& word_index == $past(word_index)
		|=> read_data == $past(data, 2))
		else $error("read after write mismatch");

endmodule

bind multi_engine_sha_peripheral mesha_chk u_mesha_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.action     (action),
	.word_index (word_index),
	.data       (data),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_data  (read_data)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the multi-engine hash peripheral: text, load, block and hash actions
// depends on mesha_pkg and the multi_engine_sha_peripheral rtl

module tb_top;

	typedef struct packed {
		logic [2:0]  action;
		logic [4:0]  word_index;
		logic [31:0] data;
		logic [1:0]  hash_type;
		logic        first_block;
	} hash_req_t;

	localparam int LIMIT_CYCLES = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [4:0]  word_index;
	logic [31:0] data;
	logic [1:0]  hash_type;
	logic        first_block;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] read_data;

	multi_engine_sha_peripheral dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.action(action), .word_index(word_index), .data(data), .hash_type(hash_type),
		.first_block(first_block), .out_valid(out_valid), .out_stall(out_stall),
		.read_data(read_data)
	);

	// predictor state
	logic [31:0] text_mirror [32];
	logic [31:0] sha1_mirror [5];
	logic [31:0] sha256_mirror [8];
	logic [63:0] sha512_mirror [8];
	logic [31:0] block_mirror [32];

	hash_req_t   pending_reqs [$];
	logic [31:0] expected_words [$];
	int          cycle_count;
	int          fail_count;
	bit          stim_done;

	function automatic logic [31:0] rl32(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] rr32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [63:0] rr64(logic [63:0] x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) w[i] = block_mirror[i];
		for (int i = 16; i < 80; i++) w[i] = rl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = sha1_mirror[0]; b = sha1_mirror[1]; c = sha1_mirror[2];
		d = sha1_mirror[3]; e = sha1_mirror[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = mesha_pkg::K1_0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = mesha_pkg::K1_1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = mesha_pkg::K1_2;
			end else begin
				f = b ^ c ^ d; k = mesha_pkg::K1_3;
			end
			t = rl32(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rl32(b, 30); b = a; a = t;
		end
		sha1_mirror[0] += a; sha1_mirror[1] += b; sha1_mirror[2] += c;
		sha1_mirror[3] += d; sha1_mirror[4] += e;
	endtask

	task automatic sha256_compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) w[i] = block_mirror[i];
		for (int i = 16; i < 64; i++) begin
			s0 = rr32(w[i-15], 7) ^ rr32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rr32(w[i-2], 17) ^ rr32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		v = sha256_mirror;
		for (int i = 0; i < 64; i++) begin
			logic [63:0] kk;
			kk = mesha_pkg::k512(7'(i));
			s1 = rr32(v[4], 6) ^ rr32(v[4], 11) ^ rr32(v[4], 25);
			t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kk[63:32] + w[i];
			s0 = rr32(v[0], 2) ^ rr32(v[0], 13) ^ rr32(v[0], 22);
			t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) sha256_mirror[i] += v[i];
	endtask

	task automatic sha512_compress();
		logic [63:0] w [80];
		logic [63:0] v [8];
		logic [63:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) w[i] = {block_mirror[2*i], block_mirror[2*i+1]};
		for (int i = 16; i < 80; i++) begin
			s0 = rr64(w[i-15], 1) ^ rr64(w[i-15], 8) ^ (w[i-15] >> 7);
			s1 = rr64(w[i-2], 19) ^ rr64(w[i-2], 61) ^ (w[i-2] >> 6);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		v = sha512_mirror;
		for (int i = 0; i < 80; i++) begin
			s1 = rr64(v[4], 14) ^ rr64(v[4], 18) ^ rr64(v[4], 41);
			t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + mesha_pkg::k512(7'(i)) + w[i];
			s0 = rr64(v[0], 28) ^ rr64(v[0], 34) ^ rr64(v[0], 39);
			t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) sha512_mirror[i] += v[i];
	endtask

	// works out the read word for one accepted transaction and updates the mirror state
	task automatic apply_action(input hash_req_t r);
		logic [31:0] res;
		res = '0;
		case (r.action)
			mesha_pkg::ACT_WRITE_TEXT: text_mirror[r.word_index] = r.data;
			mesha_pkg::ACT_READ_TEXT:  res = text_mirror[r.word_index];
			mesha_pkg::ACT_PUT_BLOCK:  block_mirror[r.word_index] = r.data;
			mesha_pkg::ACT_LOAD: begin
				if (r.hash_type == mesha_pkg::HT_SHA1)
					for (int i = 0; i < 5; i++) sha1_mirror[i] = text_mirror[i];
				else if (r.hash_type == mesha_pkg::HT_SHA256)
					for (int i = 0; i < 8; i++) sha256_mirror[i] = text_mirror[i];
				else
					for (int i = 0; i < 8; i++)
						sha512_mirror[i] = {text_mirror[2*i], text_mirror[2*i+1]};
			end
			mesha_pkg::ACT_HASH: begin
				if (r.hash_type == mesha_pkg::HT_SHA1) begin
					if (r.first_block) sha1_mirror = mesha_pkg::IV1;
					sha1_compress();
					for (int i = 0; i < 5; i++) text_mirror[i] = sha1_mirror[i];
				end else if (r.hash_type == mesha_pkg::HT_SHA256) begin
					if (r.first_block) sha256_mirror = mesha_pkg::IV256;
					sha256_compress();
					for (int i = 0; i < 8; i++) text_mirror[i] = sha256_mirror[i];
				end else begin
					if (r.first_block) begin
						if (r.hash_type == mesha_pkg::HT_SHA384)
							sha512_mirror = mesha_pkg::IV384;
						else
							sha512_mirror = mesha_pkg::IV512;
					end
					sha512_compress();
					for (int i = 0; i < 8; i++) begin
						text_mirror[2*i]   = sha512_mirror[i][63:32];
						text_mirror[2*i+1] = sha512_mirror[i][31:0];
					end
				end
			end
			default: ;
		endcase
		expected_words.push_back(res);
	endtask

	function automatic hash_req_t mk(logic [2:0] a, logic [4:0] idx, logic [31:0] d,
			logic [1:0] ht, logic fb);
		hash_req_t r;
		r.action = a; r.word_index = idx; r.data = d; r.hash_type = ht; r.first_block = fb;
		return r;
	endfunction

	function automatic hash_req_t rand_req(logic [2:0] a);
		return mk(a, 5'($urandom), $urandom, 2'($urandom), 1'($urandom));
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stimulus: all 32 block words are written first so no hash ever reads an unwritten entry
	initial begin
		int n, blen;
		arst_n = 1'b0;
		stim_done = 1'b0;
		// mirror state matches the reset values of the block; the block buffer is not cleared, its mirror starts at zero
		for (int i = 0; i < 32; i++) begin
			text_mirror[i] = 32'h0;
			block_mirror[i] = 32'h0;
		end
		for (int i = 0; i < 5; i++) sha1_mirror[i] = 32'h0;
		for (int i = 0; i < 8; i++) begin
			sha256_mirror[i] = 32'h0;
			sha512_mirror[i] = 64'h0;
		end
		for (int i = 0; i < 32; i++) pending_reqs.push_back(mk(mesha_pkg::ACT_PUT_BLOCK, 5'(i),
			(i == 0) ? 32'h61626380 : (i == 31) ? 32'h18 : (i == 1) ? 32'hffffffff : 32'h0,
			mesha_pkg::HT_SHA1, 1'b0));
		// directed: first blocks on each algorithm, extremes, unused codes
		pending_reqs.push_back(mk(mesha_pkg::ACT_HASH, 5'd0, 32'h0, mesha_pkg::HT_SHA1, 1'b1));
		pending_reqs.push_back(mk(mesha_pkg::ACT_READ_TEXT, 5'd0, 32'h0,
			mesha_pkg::HT_SHA1, 1'b0));
		pending_reqs.push_back(mk(mesha_pkg::ACT_HASH, 5'd0, 32'h0,
			mesha_pkg::HT_SHA256, 1'b1));
		pending_reqs.push_back(mk(mesha_pkg::ACT_HASH, 5'd0, 32'h0,
			mesha_pkg::HT_SHA384, 1'b1));
		pending_reqs.push_back(mk(mesha_pkg::ACT_HASH, 5'd0, 32'h0,
			mesha_pkg::HT_SHA512, 1'b1));
		pending_reqs.push_back(mk(mesha_pkg::ACT_READ_TEXT, 5'd15, 32'h0,
			mesha_pkg::HT_SHA1, 1'b0));
		pending_reqs.push_back(mk(mesha_pkg::ACT_WRITE_TEXT, 5'd31, 32'hffffffff,
			mesha_pkg::HT_SHA512, 1'b1));
		pending_reqs.push_back(mk(mesha_pkg::ACT_READ_TEXT, 5'd31, 32'h0,
			mesha_pkg::HT_SHA512, 1'b1));
		pending_reqs.push_back(mk(mesha_pkg::ACT_LOAD, 5'd0, 32'h0, mesha_pkg::HT_SHA1, 1'b0));
		pending_reqs.push_back(mk(mesha_pkg::ACT_LOAD, 5'd0, 32'h0,
			mesha_pkg::HT_SHA256, 1'b0));
		pending_reqs.push_back(mk(mesha_pkg::ACT_LOAD, 5'd0, 32'h0,
			mesha_pkg::HT_SHA384, 1'b0));
		pending_reqs.push_back(mk(mesha_pkg::ACT_HASH, 5'd0, 32'h0,
			mesha_pkg::HT_SHA512, 1'b0));
		pending_reqs.push_back(mk(3'd5, 5'd3, 32'hffffffff, mesha_pkg::HT_SHA512, 1'b1));
		pending_reqs.push_back(mk(3'd6, 5'd0, 32'h0, mesha_pkg::HT_SHA1, 1'b0));
		pending_reqs.push_back(mk(3'd7, 5'd31, 32'h12345678, mesha_pkg::HT_SHA256, 1'b1));
		pending_reqs.push_back(mk(mesha_pkg::ACT_READ_TEXT, 5'd3, 32'h0,
			mesha_pkg::HT_SHA1, 1'b0));
		// random: mostly well-formed block fill, optional state load, hash, read back
		n = 0;
		while (n < 400) begin
			if ($urandom_range(0, 3) != 0) begin
				blen = $urandom_range(0, 1) ? 32 : $urandom_range(1, 16);
				for (int i = 0; i < blen; i++)
					pending_reqs.push_back(mk(mesha_pkg::ACT_PUT_BLOCK, 5'(i), $urandom,
						2'($urandom), 1'($urandom)));
				if ($urandom_range(0, 2) == 0) begin
					for (int i = 0; i < 16; i++)
						pending_reqs.push_back(mk(mesha_pkg::ACT_WRITE_TEXT, 5'(i), $urandom,
							2'($urandom), 1'($urandom)));
					pending_reqs.push_back(rand_req(mesha_pkg::ACT_LOAD));
					n += 17;
				end
				pending_reqs.push_back(rand_req(mesha_pkg::ACT_HASH));
				for (int i = 0; i < 4; i++)
					pending_reqs.push_back(rand_req(mesha_pkg::ACT_READ_TEXT));
				n += blen + 5;
			end else begin
				pending_reqs.push_back(rand_req(3'($urandom)));
				n++;
			end
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0);
		stim_done = 1'b1;
	end

	// driver: bursts of random length, random gaps
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= '0; word_index <= '0; data <= '0; hash_type <= '0; first_block <= 1'b0;
			burst_left <= 0; gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_action({action, word_index, data, hash_type, first_block});
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					hash_req_t r;
					r = pending_reqs.pop_front();
					{action, word_index, data, hash_type, first_block} <= r;
					in_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern with one long hold-off to back the block up
	int stall_phase, hold_off;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_phase <= 0; hold_off <= 0; hold_done <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (!hold_done && cycle_count == 300) begin
				hold_off <= 400;
				hold_done <= 1'b1;
				out_stall <= 1'b1;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_stall <= 1'b1;
			end else if (stall_phase[9]) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// monitor: compares each accepted transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected result read_data=%h", read_data);
				fail_count++;
			end else begin
				logic [31:0] exp_word;
				exp_word = expected_words.pop_front();
				if (read_data !== exp_word) begin
					$error("read_data mismatch: expected %h actual %h", exp_word, read_data);
					fail_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		fail_count = 0;
		fork
			begin
				wait (stim_done);
				@(posedge clk);
				while (in_valid || expected_words.size() != 0) @(posedge clk);
				repeat (150) @(posedge clk);
				if (fail_count == 0 && expected_words.size() == 0)
					$display("Verification passed");
				else
					$display("Verification failed");
			end
			begin
				while (cycle_count < LIMIT_CYCLES) begin
					@(posedge clk);
					cycle_count++;
				end
				$display("Verification failed");
			end
		join_any
		$finish;
	end

endmodule
